[src/dsq_pkg.sv]
// Package for the delta sleep queue: entry, token and control types,
// operation and status codes, field widths and default sizes.
// No dependencies.
package dsq_pkg;

  // Default sizes
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned MaxResults    = 16;

  // Field widths
  localparam int unsigned DeltaW   = 32;
  localparam int unsigned IdW      = 8;
  localparam int unsigned OpW      = 3;
  localparam int unsigned LenW     = 5;
  localparam int unsigned InDataW  = 40;  // thread_id, amount
  localparam int unsigned InUserW  = 3;   // op
  localparam int unsigned OutDataW = 16;  // woken_id, queue_length, pad
  localparam int unsigned OutUserW = 3;   // status, released

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 3'd0,
    OP_TICK    = 3'd1,
    OP_INCR    = 3'd2,
    OP_WAKE    = 3'd3,
    OP_SNOOZE  = 3'd4,
    OP_RELEASE = 3'd5
  } dsq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } dsq_status_e;

  // One queue entry: delta after its predecessor and thread id
  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [IdW-1:0]    id;
  } dsq_entry_t;

  // Insert token walking down the chain
  typedef struct packed {
    logic              vld;
    logic [DeltaW-1:0] rem;
    logic [IdW-1:0]    id;
  } dsq_tok_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              pop;
    logic              head_wr;
    logic [DeltaW-1:0] head_delta;
    logic              tok_start;
    logic [DeltaW-1:0] new_rem;
    logic [IdW-1:0]    new_id;
    logic              place;
  } dsq_ctrl_t;

endpackage

[src/dsq_cell.sv]
// One cell of the delta sleep queue chain: holds one entry and the insert
// token slot; shifts with its neighbors on pop and insert.
// Depends on dsq_pkg.
module dsq_cell import dsq_pkg::*; #(
  parameter bit IsHead = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dsq_ctrl_t  ctrl_i,
  input  logic       occ_i,        // entry holds a sleeping thread
  input  dsq_entry_t left_shift_i, // entry offered by the left neighbor
  input  dsq_tok_t   left_tok_i,   // token handed on by the left neighbor
  input  dsq_entry_t right_ent_i,  // entry of the right neighbor
  output dsq_entry_t ent_o,
  output dsq_entry_t shift_o,
  output dsq_tok_t   tok_o,
  output logic       place_o
);

  dsq_entry_t ent_q, ent_d;
  logic       tok_vld_q, tok_vld_d;
  logic [DeltaW-1:0] tok_rem_q, tok_rem_d;
  logic [IdW-1:0]    tok_id_q, tok_id_d;
  logic       passed_q, passed_d;
  logic       here, lt;

  // Token compare: move on past a strictly smaller delta
  always_comb begin
    here    = tok_vld_q;
    lt      = occ_i && (ent_q.delta < tok_rem_q);
    place_o = here && !lt;
    tok_o.vld = here && lt;
    tok_o.rem = tok_rem_q - ent_q.delta;
    tok_o.id  = tok_id_q;
    // The entry displaced by a new one loses the new delta
    if (place_o) begin
      shift_o.delta = ent_q.delta - tok_rem_q;
      shift_o.id    = ent_q.id;
    end else begin
      shift_o = ent_q;
    end
  end

  // Token slot and passed flag
  always_comb begin
    if (ctrl_i.tok_start) begin
      tok_vld_d = IsHead;
      tok_rem_d = ctrl_i.new_rem;
      tok_id_d  = ctrl_i.new_id;
      passed_d  = 1'b0;
    end else begin
      tok_vld_d = left_tok_i.vld;
      tok_rem_d = left_tok_i.rem;
      tok_id_d  = left_tok_i.id;
      passed_d  = passed_q | (here && lt);
    end
  end

  // Entry update
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.pop) begin
      ent_d = right_ent_i;
    end else if (ctrl_i.head_wr && IsHead) begin
      ent_d.delta = ctrl_i.head_delta;
    end else if (ctrl_i.place && !passed_q) begin
      if (here) begin
        ent_d.delta = tok_rem_q;
        ent_d.id    = tok_id_q;
      end else begin
        ent_d = left_shift_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      passed_q  <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_d;
      passed_q  <= passed_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    tok_rem_q <= tok_rem_d;
    tok_id_q  <= tok_id_d;
  end

  assign ent_o = ent_q;

endmodule

[src/delta_sleep_queue.sv]
// Delta sleep queue, top level: request sequencer, output register and
// the chain of dsq_cell entries. Depends on dsq_pkg and dsq_cell.
//
//   Requests come in on the s_axis channel: tuser carries the operation,
//   tdata the thread id and the delay amount. Results leave on m_axis:
//   tuser carries status and released, tdata woken id and queue length,
//   tlast marks the final result of a request.
//   Every request passes through an accept step and an execute step; its first
//   result is registered at the end of the execute step, except for a
//   release that wakes threads, whose first result comes from the release step.
//   Insert: the token walks one cell per cycle and the block stays busy
//   until a cell takes it; its result is out before the walk ends.
//   Release: after the execute step, one result per woken thread (up to
//   16), each when the output register is free; tick, increment, wake and
//   snooze finish in the execute step.
//   A request is accepted whenever the sequencer is idle, even with a result
//   still waiting; on a receiver stall the sequencer holds in its execute or
//   release step until the output register frees up.
//   Reset empties the queue and the output register; the entry contents
//   are not cleared since only occupied cells are ever read.
module delta_sleep_queue import dsq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // thread_id[7:0], amount[39:8]
  input  logic [InUserW-1:0]  s_axis_tuser,   // op[2:0]
  // Result channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // woken_id[7:0], queue_length[12:8]
  output logic [OutUserW-1:0] m_axis_tuser,   // status[1:0], released[2]
  output logic                m_axis_tlast
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RelW = $clog2(MaxResults);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_REL  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  dsq_op_e           op_q, op_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [DeltaW-1:0] amt_q, amt_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RelW-1:0]   rel_n_q, rel_n_d;

  // Output register
  logic              m_valid_q, m_valid_d;
  dsq_status_e       m_status_q, m_status_d;
  logic [IdW-1:0]    m_woken_q, m_woken_d;
  logic              m_rel_q, m_rel_d;
  logic              m_last_q, m_last_d;
  logic [LenW-1:0]   m_len_q, m_len_d;

  // Result being produced this cycle
  logic              emit;
  dsq_status_e       e_status;
  logic [IdW-1:0]    e_woken;
  logic              e_rel;
  logic              e_last;
  logic [CntW-1:0]   e_len;
  logic [31:0]       e_len_ext;

  dsq_ctrl_t         ctrl;
  dsq_entry_t        ent     [QUEUE_DEPTH];
  dsq_entry_t        shift_v [QUEUE_DEPTH];
  dsq_tok_t          tok_v   [QUEUE_DEPTH];
  dsq_entry_t        left_shift [QUEUE_DEPTH];
  dsq_tok_t          left_tok   [QUEUE_DEPTH];
  dsq_entry_t        right_ent  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] place_v, occ_v;

  logic              slot_free;
  logic [DeltaW-1:0] d0, head_new;
  logic [DeltaW:0]   snooze_sum;
  logic              rel_last;

  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Cell chain
  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    assign occ_v[j] = (CntW'(j) < cnt_q);
    if (j == 0) begin : g_first
      assign left_shift[j] = '0;
      assign left_tok[j]   = '0;
    end else begin : g_mid
      assign left_shift[j] = shift_v[j-1];
      assign left_tok[j]   = tok_v[j-1];
    end
    if (j == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent[j] = ent[j];
    end else begin : g_body
      assign right_ent[j] = ent[j+1];
    end

    dsq_cell #(
      .IsHead (j == 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .occ_i        (occ_v[j]),
      .left_shift_i (left_shift[j]),
      .left_tok_i   (left_tok[j]),
      .right_ent_i  (right_ent[j]),
      .ent_o        (ent[j]),
      .shift_o      (shift_v[j]),
      .tok_o        (tok_v[j]),
      .place_o      (place_v[j])
    );
  end

  // Head delta update for tick, increment, wake and snooze
  always_comb begin
    d0         = ent[0].delta;
    snooze_sum = {1'b0, d0} + {1'b0, amt_q};
    case (op_q)
      OP_TICK:   head_new = (d0 != '0) ? d0 - DeltaW'(1) : d0;
      OP_INCR:   head_new = (d0 != '1) ? d0 + DeltaW'(1) : d0;
      OP_WAKE:   head_new = '0;
      OP_SNOOZE: head_new = snooze_sum[DeltaW] ? '1 : snooze_sum[DeltaW-1:0];
      default:   head_new = d0;
    endcase
  end

  // Release ends after this pop
  assign rel_last = (cnt_q == CntW'(1)) || (ent[1].delta != '0) ||
                    (rel_n_q == RelW'(MaxResults - 1));

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    id_d     = id_q;
    amt_d    = amt_q;
    cnt_d    = cnt_q;
    rel_n_d  = rel_n_q;
    emit     = 1'b0;
    e_status = ST_OK;
    e_woken  = '0;
    e_rel    = 1'b0;
    e_last   = 1'b1;
    e_len    = cnt_q;
    ctrl            = '0;
    ctrl.head_delta = head_new;
    ctrl.new_rem    = amt_q;
    ctrl.new_id     = id_q;
    ctrl.place      = |place_v;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = dsq_op_e'(s_axis_tuser[OpW-1:0]);
          id_d    = s_axis_tdata[IdW-1:0];
          amt_d   = s_axis_tdata[IdW +: DeltaW];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
          case (op_q) inside
            OP_INSERT: begin
              emit = 1'b1;
              if (amt_q == '0) begin
                e_status = ST_ZERO;
              end else if (cnt_q == CntW'(QUEUE_DEPTH)) begin
                e_status = ST_FULL;
              end else begin
                e_len          = cnt_q + CntW'(1);
                ctrl.tok_start = 1'b1;
                state_d        = S_WALK;
              end
            end
            OP_RELEASE: begin
              if (cnt_q == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else if (d0 != '0) begin
                emit = 1'b1;
              end else begin
                rel_n_d = '0;
                state_d = S_REL;
              end
            end
            OP_TICK, OP_INCR, OP_WAKE, OP_SNOOZE: begin
              emit         = 1'b1;
              ctrl.head_wr = (cnt_q != '0);
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (ctrl.place) begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = S_IDLE;
        end
      end
      S_REL: begin
        if (slot_free) begin
          ctrl.pop = 1'b1;
          cnt_d    = cnt_q - CntW'(1);
          emit     = 1'b1;
          e_woken  = ent[0].id;
          e_rel    = 1'b1;
          e_last   = rel_last;
          e_len    = cnt_q - CntW'(1);
          rel_n_d  = rel_n_q + RelW'(1);
          if (rel_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register load
  always_comb begin
    e_len_ext  = 32'(e_len);
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_woken_d  = m_woken_q;
    m_rel_d    = m_rel_q;
    m_last_d   = m_last_q;
    m_len_d    = m_len_q;
    if (emit) begin
      m_valid_d  = 1'b1;
      m_status_d = e_status;
      m_woken_d  = e_woken;
      m_rel_d    = e_rel;
      m_last_d   = e_last;
      m_len_d    = e_len_ext[LenW-1:0];
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    amt_q      <= amt_d;
    rel_n_q    <= rel_n_d;
    m_status_q <= m_status_d;
    m_woken_q  <= m_woken_d;
    m_rel_q    <= m_rel_d;
    m_last_q   <= m_last_d;
    m_len_q    <= m_len_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - LenW - IdW){1'b0}}, m_len_q, m_woken_q};
  assign m_axis_tuser  = {m_rel_q, m_status_q};
  assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
  // Only one cell may take the insert token in a cycle
  a_place_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(place_v))
    else $error("more than one cell claims the insert token");

  // A placement happens only during an insert walk
  a_place_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|place_v) |-> (state_q == S_WALK))
    else $error("insert placement outside of a walk");

  // Occupancy never exceeds the chain length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // A pop only takes an occupied head whose delta has run out
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> ((cnt_q != '0) && (ent[0].delta == '0)))
    else $error("pop of an empty queue or an unexpired head");

  // A walk finishes with one more entry
  a_walk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) && (|place_v)) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert walk did not grow the queue");
`endif

endmodule
